// ===== hdl/touch_packet_decoder_pen_up_timer_unit_macros.svh =====
// Assertion macros for the touch packet decoder with pen-up timer.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef TOUCH_PACKET_DECODER_PEN_UP_TIMER_UNIT_MACROS_SVH
`define TOUCH_PACKET_DECODER_PEN_UP_TIMER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define TPD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a same-cycle implication on every clock edge outside reset
`define TPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tpdpu_pkg.sv =====
// Shared types and constants for the touch packet decoder with pen-up timer.
// No dependencies; imported by the decode logic, result buffer and top level.
package tpdpu_pkg;

    localparam int BYTE_W   = 8;
    localparam int LOW_W    = 7;
    localparam int HDR_W    = 6;
    localparam int COORD_W  = 10;
    localparam int EXTRA_W  = 10;
    localparam int WAIT_W   = 11;
    localparam int HDR_BIT  = 7;

    // Item kinds on the input channel
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds
    localparam logic TOUCH_UP   = 1'b0;
    localparam logic TOUCH_DOWN = 1'b1;

    // Position inside a three-byte packet
    typedef enum logic [1:0] {
        POS_HEADER,
        POS_SECOND,
        POS_THIRD
    } byte_pos_t;

    typedef struct packed {
        logic [HDR_W-1:0]   hdr_bits;
        logic [LOW_W-1:0]   first_low;
        byte_pos_t          byte_pos;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [WAIT_W-1:0]  wait_count;
        logic               timer_running;
    } dec_state_t;

    typedef struct packed {
        logic               touch;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } result_t;

    // Status of the two-entry result buffer
    typedef struct packed {
        logic head_valid;
        logic skid_valid;
    } buf_stat_t;

endpackage

// ===== hdl/tpdpu_decode.sv =====
// Next-state and result logic for one item of the touch packet decoder.
// Purely combinational; depends on tpdpu_pkg.
module tpdpu_decode (
    input  tpdpu_pkg::dec_state_t             state,
    input  logic                              mode,
    input  logic [tpdpu_pkg::BYTE_W-1:0]      data_byte,
    input  logic [tpdpu_pkg::WAIT_W-1:0]      wait_reload,
    output tpdpu_pkg::dec_state_t             state_next,
    output logic                              emit,
    output tpdpu_pkg::result_t                result
);
    import tpdpu_pkg::*;

    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;

    // Assemble coordinates from header bits and low seven bits
    assign raw_x = {state.hdr_bits[5:3], state.first_low};
    assign raw_y = {state.hdr_bits[2:0], data_byte[LOW_W-1:0]};

    always_comb begin
        state_next   = state;
        emit         = 1'b0;
        result.touch = TOUCH_UP;
        result.pos_x = state.last_x;
        result.pos_y = state.last_y;

        if (mode == MODE_TICK) begin
            // Count down the pen-up timer; report pen-up on expiry
            if (state.timer_running) begin
                if (state.wait_count <= WAIT_W'(1)) begin
                    state_next.wait_count    = '0;
                    state_next.timer_running = 1'b0;
                    emit                     = 1'b1;
                end else begin
                    state_next.wait_count = state.wait_count - WAIT_W'(1);
                end
            end
        end else begin
            // Any byte restarts the timer
            state_next.wait_count    = wait_reload;
            state_next.timer_running = 1'b1;
            if (data_byte[HDR_BIT]) begin
                state_next.hdr_bits = data_byte[HDR_W-1:0];
                state_next.byte_pos = POS_SECOND;
            end else begin
                unique case (state.byte_pos)
                    POS_SECOND: begin
                        state_next.first_low = data_byte[LOW_W-1:0];
                        state_next.byte_pos  = POS_THIRD;
                    end
                    POS_THIRD: begin
                        // X is mirrored: 1023 - x equals the bitwise inverse
                        state_next.last_x   = ~raw_x;
                        state_next.last_y   = raw_y;
                        state_next.byte_pos = POS_HEADER;
                        emit                = 1'b1;
                        result.touch        = TOUCH_DOWN;
                        result.pos_x        = ~raw_x;
                        result.pos_y        = raw_y;
                    end
                    default: begin
                        // Drop a stray byte outside a packet
                        state_next.byte_pos = POS_HEADER;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/tpdpu_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Lets the decoder take an item while a result waits; depends on tpdpu_pkg.
module tpdpu_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tpdpu_pkg::result_t    push_data,
    input  logic                  pop_ready,
    output tpdpu_pkg::buf_stat_t  stat,
    output tpdpu_pkg::result_t    head_data
);
    import tpdpu_pkg::*;

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_data_reg,  head_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    pop;

    assign pop = head_valid_reg & pop_ready;

    // Move items between skid, head and output
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_data_next  = head_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                head_data_next = push_data;
            end else begin
                head_valid_next = 1'b0;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end else begin
                head_data_next  = push_data;
                head_valid_next = 1'b1;
            end
        end
    end

    // Hold flags under reset; payload needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_data_reg <= head_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign stat.head_valid = head_valid_reg;
    assign stat.skid_valid = skid_valid_reg;
    assign head_data       = head_data_reg;

endmodule

// ===== hdl/touch_packet_decoder_pen_up_timer_unit.sv =====
// Touch packet decoder with pen-up timer. Takes one item (a controller byte or a
// 10 ms tick) per clock cycle while s_ready is high and gives at most one result
// per item: a pen-down event after the third byte of a packet, or a pen-up event
// when BASE_WAIT_TICKS plus extra_wait ticks pass with no byte. Decode and timer
// state update in the cycle an item is accepted; the result is held in an output
// register driving the m_ side. A skid register behind it keeps s_ready high until
// two results are waiting, so a stalled output costs throughput only after that.
// Depends on tpdpu_pkg, tpdpu_decode, tpdpu_out_buf and the assertion macro header.
`include "touch_packet_decoder_pen_up_timer_unit_macros.svh"

module touch_packet_decoder_pen_up_timer_unit #(
    parameter int BASE_WAIT_TICKS = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tpdpu_pkg::EXTRA_W-1:0]      cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [tpdpu_pkg::BYTE_W-1:0]       s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_touch,
    output logic [tpdpu_pkg::COORD_W-1:0]      m_pos_x,
    output logic [tpdpu_pkg::COORD_W-1:0]      m_pos_y
);
    import tpdpu_pkg::*;

    logic [EXTRA_W-1:0] extra_wait_reg;
    dec_state_t         state_reg;
    dec_state_t         state_next;
    logic [WAIT_W-1:0]  wait_reload;
    logic               accept;
    logic               emit;
    result_t            result;
    buf_stat_t          buf_stat;
    result_t            head_data;

    assign wait_reload = WAIT_W'(BASE_WAIT_TICKS) + WAIT_W'(extra_wait_reg);
    assign accept      = s_valid & s_ready;
    assign s_ready     = ~buf_stat.skid_valid;

    // Hold the timeout extension register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_wait_reg <= '0;
        end else if (cfg_we) begin
            extra_wait_reg <= cfg_wdata;
        end
    end

    tpdpu_decode u_decode (
        .state       (state_reg),
        .mode        (s_mode),
        .data_byte   (s_data_byte),
        .wait_reload (wait_reload),
        .state_next  (state_next),
        .emit        (emit),
        .result      (result)
    );

    // Advance decoder state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.hdr_bits      <= '0;
            state_reg.first_low     <= '0;
            state_reg.byte_pos      <= POS_HEADER;
            state_reg.last_x        <= '0;
            state_reg.last_y        <= '0;
            state_reg.wait_count    <= '0;
            state_reg.timer_running <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    tpdpu_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept & emit),
        .push_data (result),
        .pop_ready (m_ready),
        .stat      (buf_stat),
        .head_data (head_data)
    );

    assign m_valid = buf_stat.head_valid;
    assign m_touch = head_data.touch;
    assign m_pos_x = head_data.pos_x;
    assign m_pos_y = head_data.pos_y;

    // Idle timer always has a cleared count
    `TPD_ASSERT_IMPL(a_idle_timer_clear, !state_reg.timer_running, state_reg.wait_count == '0, "timer idle with nonzero count")

    // Skid entry only fills behind a waiting head
    `TPD_ASSERT_IMPL(a_skid_behind_head, buf_stat.skid_valid, buf_stat.head_valid, "skid holds item with empty head")

    // Pen-down only on a third data byte
    `TPD_ASSERT_IMPL(a_pen_down_third, accept && emit && result.touch == TOUCH_DOWN, s_mode == MODE_BYTE && !s_data_byte[HDR_BIT] && state_reg.byte_pos == POS_THIRD, "pen-down outside third byte")

    // Every byte restarts the timer at the full timeout
    `TPD_ASSERT_CLK(a_byte_restarts, (accept && s_mode == MODE_BYTE) |=> (state_reg.timer_running && state_reg.wait_count == $past(wait_reload)), "byte did not restart timer")

endmodule
